FILE: rtl/core/diseqc_byte_burst_encoder_defines.svh
// ============================================================================
// DiSEqC byte burst encoder: assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ============================================================================
`ifndef DISEQC_BYTE_BURST_ENCODER_DEFINES_SVH
`define DISEQC_BYTE_BURST_ENCODER_DEFINES_SVH

// same-cycle implication
`define DBBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DBBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dbbe_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dbbe_pkg
// Types, widths, register indexes and reset values of the burst encoder.
// ============================================================================
package dbbe_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF       = 2;

    localparam int LEVEL_W    = 6;
    localparam int TIME_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int NUM_BITS   = 9;
    localparam int BIT_CNT_W  = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_CARRIER_LEVEL = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_ON_TIME   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_OFF_TIME  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_ON_TIME  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFF_TIME = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET         = 6'd22;
    localparam logic [TIME_W-1:0]  ONE_ON_TIME_RESET   = 16'd500;
    localparam logic [TIME_W-1:0]  ONE_OFF_TIME_RESET  = 16'd1000;
    localparam logic [TIME_W-1:0]  ZERO_ON_TIME_RESET  = 16'd1000;
    localparam logic [TIME_W-1:0]  ZERO_OFF_TIME_RESET = 16'd500;

    typedef struct packed {
        logic [LEVEL_W-1:0] carrier_level;
        logic [TIME_W-1:0]  one_on_time;
        logic [TIME_W-1:0]  one_off_time;
        logic [TIME_W-1:0]  zero_on_time;
        logic [TIME_W-1:0]  zero_off_time;
    } cfg_t;

    // bits[NUM_BITS-1] goes out first; parity sits in bits[0]
    typedef struct packed {
        logic [NUM_BITS-1:0] bits;
        logic                eom;
        logic                too_long;
    } q_entry_t;

    localparam int Q_ENTRY_W = $bits(q_entry_t);

endpackage

FILE: rtl/core/dbbe_front.sv
`timescale 1ns / 1ps
// ============================================================================
// dbbe_front
// Accept message bytes, count the message length, add odd parity and
// classify each byte as sent or dropped before queueing it.
// ============================================================================
module dbbe_front #(
    parameter int MAX_MESSAGE_BYTES = dbbe_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dbbe_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    output logic                         q_push,
    output dbbe_pkg::q_entry_t           q_wdata,
    input  logic                         q_full
);
    import dbbe_pkg::*;

    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE_BYTES);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             too_long;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign too_long = (cnt_reg >= CNT_MAX);

    always_comb begin
        q_wdata.bits     = {s_tdata, ~^s_tdata};
        q_wdata.eom      = s_tlast;
        q_wdata.too_long = too_long;
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) begin
            if (s_tlast) begin
                cnt_next = '0;
            end else if (too_long) begin
                cnt_next = CNT_MAX;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/dbbe_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// dbbe_fifo
// Short register queue between the front and the back; first word fall-through.
// ============================================================================
`include "diseqc_byte_burst_encoder_defines.svh"

module dbbe_fifo #(
    parameter int WIDTH = dbbe_pkg::Q_ENTRY_W,
    parameter int DEPTH = dbbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import dbbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DBBE_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !full, "push into full queue")
    `DBBE_ASSERT_NXT(a_count_up, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "queue count did not advance")

endmodule

FILE: rtl/core/dbbe_back.sv
`timescale 1ns / 1ps
// ============================================================================
// dbbe_back
// Segment sequencer: each queued byte becomes ON and OFF segments, one per
// unstalled cycle, or one error segment if dropped, into an output register.
// ============================================================================
`include "diseqc_byte_burst_encoder_defines.svh"

module dbbe_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dbbe_pkg::cfg_t                cfg,
    input  dbbe_pkg::q_entry_t            q_rdata,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,
    output logic                          m_tlast,
    output logic [1:0]                    m_tuser
);
    import dbbe_pkg::*;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(NUM_BITS - 1);

    q_entry_t               hold_reg, src;
    logic                   busy_reg;
    logic                   phase_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic                   m_tvalid_reg;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic                   bdone_reg, bdone_next;
    logic                   mdone_reg, mdone_next;
    logic                   tl_reg, tl_next;
    logic                   have, out_free, step, last_seg, cur_bit;

    assign src      = busy_reg ? hold_reg : q_rdata;
    assign have     = busy_reg || !q_empty;
    assign out_free = !m_tvalid_reg || m_tready;
    assign step     = out_free && have;
    assign q_pop    = step && !busy_reg;
    assign cur_bit  = src.bits[NUM_BITS-1];
    assign last_seg = src.too_long || (phase_reg && (bit_cnt_reg == LAST_BIT));

    always_comb begin
        if (src.too_long) begin
            level_next = '0;
            time_next  = '0;
            bdone_next = 1'b1;
            mdone_next = src.eom;
            tl_next    = 1'b1;
        end else if (!phase_reg) begin
            level_next = cfg.carrier_level;
            time_next  = cur_bit ? cfg.one_on_time : cfg.zero_on_time;
            bdone_next = 1'b0;
            mdone_next = 1'b0;
            tl_next    = 1'b0;
        end else begin
            level_next = '0;
            time_next  = cur_bit ? cfg.one_off_time : cfg.zero_off_time;
            bdone_next = last_seg;
            mdone_next = last_seg && src.eom;
            tl_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            phase_reg    <= 1'b0;
            bit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (step) begin
                m_tvalid_reg <= 1'b1;
                if (last_seg) begin
                    busy_reg    <= 1'b0;
                    phase_reg   <= 1'b0;
                    bit_cnt_reg <= '0;
                end else begin
                    busy_reg  <= 1'b1;
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    end
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            level_reg         <= level_next;
            time_reg          <= time_next;
            bdone_reg         <= bdone_next;
            mdone_reg         <= mdone_next;
            tl_reg            <= tl_next;
            hold_reg.eom      <= src.eom;
            hold_reg.too_long <= src.too_long;
            hold_reg.bits     <= phase_reg ? {src.bits[NUM_BITS-2:0], 1'b0} : src.bits;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, time_reg, level_reg};
    assign m_tlast  = bdone_reg;
    assign m_tuser  = {tl_reg, mdone_reg};

    `DBBE_ASSERT_IMP(a_err_ends_byte, aclk, aresetn, m_tvalid && m_tuser[1],
                     m_tlast && (m_tdata == '0), "error segment not a lone zero segment")
    `DBBE_ASSERT_IMP(a_busy_not_err, aclk, aresetn, busy_reg, !hold_reg.too_long,
                     "dropped byte held in sequencer")
    `DBBE_ASSERT_IMP(a_bit_range, aclk, aresetn, 1'b1, bit_cnt_reg <= LAST_BIT,
                     "bit counter out of range")

endmodule

FILE: rtl/core/diseqc_byte_burst_encoder.sv
`timescale 1ns / 1ps
// ============================================================================
// diseqc_byte_burst_encoder
// Message byte to DiSEqC carrier segment encoder with message length check.
// ============================================================================
// Each byte on s_ becomes 18 segments on m_: per bit, MSB first then odd
// parity, an ON segment at carrier_level and an OFF segment at level 0. A
// byte beyond MAX_MESSAGE_BYTES in a message is dropped and gives one error
// segment. The back sequencer emits one segment per cycle unless m_tready
// stalls it; the front takes one byte per cycle while the queue is not
// full, into a two-entry queue, so the next byte is accepted while the
// current one plays out. Write configuration only while the block is idle.
module diseqc_byte_burst_encoder #(
    parameter int MAX_MESSAGE_BYTES = dbbe_pkg::MAX_MESSAGE_BYTES_DEF,
    parameter int QUEUE_DEPTH       = dbbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dbbe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dbbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // end_of_message
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // [5:0] segment_level,
                                                        // [21:6] segment_time
    output logic                             m_tlast,   // byte_done
    output logic [1:0]                       m_tuser    // [0] message_done,
                                                        // [1] too_long
);
    import dbbe_pkg::*;

    cfg_t     cfg_reg;
    q_entry_t q_wdata, q_rdata;
    logic     q_push, q_pop, q_full, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.carrier_level <= LEVEL_RESET;
            cfg_reg.one_on_time   <= ONE_ON_TIME_RESET;
            cfg_reg.one_off_time  <= ONE_OFF_TIME_RESET;
            cfg_reg.zero_on_time  <= ZERO_ON_TIME_RESET;
            cfg_reg.zero_off_time <= ZERO_OFF_TIME_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CARRIER_LEVEL: cfg_reg.carrier_level <= cfg_wdata[LEVEL_W-1:0];
                REG_ONE_ON_TIME:   cfg_reg.one_on_time   <= cfg_wdata[TIME_W-1:0];
                REG_ONE_OFF_TIME:  cfg_reg.one_off_time  <= cfg_wdata[TIME_W-1:0];
                REG_ZERO_ON_TIME:  cfg_reg.zero_on_time  <= cfg_wdata[TIME_W-1:0];
                REG_ZERO_OFF_TIME: cfg_reg.zero_off_time <= cfg_wdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dbbe_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full)
    );

    dbbe_fifo #(
        .WIDTH(Q_ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .empty  (q_empty)
    );

    dbbe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_rdata (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule
